>>> hdl/sgm_pkg.sv
// ----------------------------------------------------------------------------
// sgm_pkg
// Shared constants, types and helpers for the Sobel gradient magnitude block.
// ----------------------------------------------------------------------------
package sgm_pkg;

    localparam int MaxWidth  = 4096;
    localparam int MaxHeight = 4096;
    localparam int MinDim    = 3;
    localparam int PixW      = 8;
    localparam int ColW      = 12;
    localparam int DimW      = 13;
    localparam int CfgIdxW   = 1;
    localparam int QDepth    = 4;
    localparam int QPtrW     = 2;
    localparam int QCntW     = 3;
    localparam int GradW     = 11;
    localparam int AbsW      = 10;
    localparam int SqW       = 20;
    localparam int SumW      = 21;
    localparam int RootBits  = 8;
    localparam int SatLevel  = 255;

    localparam logic [DimW-1:0] WidthReset  = 13'd640;
    localparam logic [DimW-1:0] HeightReset = 13'd480;

    typedef enum logic [CfgIdxW-1:0] {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } t_cfg_reg;

    // One classified pixel request on its way from the front to the back.
    typedef struct packed {
        logic [PixW-1:0] px;
        logic [ColW-1:0] col;
        logic            wr;    // column inside the frame: update line store and window
        logic            prod;  // interior pixel: a magnitude comes out
        logic            fend;  // last interior pixel of the frame
    } t_item;

    function automatic logic [DimW-1:0] clamp_dim(input logic [DimW-1:0] v,
                                                  input logic [DimW-1:0] hi);
        logic [DimW-1:0] r;
        r = v;
        if (v < DimW'(MinDim)) r = DimW'(MinDim);
        else if (v > hi)       r = hi;
        return r;
    endfunction

endpackage

>>> hdl/sgm_front.sv
// ----------------------------------------------------------------------------
// sgm_front
// Configuration registers, raster position counters and request classification.
// ----------------------------------------------------------------------------
module sgm_front import sgm_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [CfgIdxW-1:0] i_cfg_idx,
    input  logic [DimW-1:0]    i_cfg_data,
    input  logic               i_pix_valid,
    output logic               o_pix_ready,
    input  logic [PixW-1:0]    i_pixel_value,
    input  logic               i_frame_start,
    input  logic               i_q_full,
    output logic               o_push,
    output t_item              o_item
);

    logic [DimW-1:0] r_width, r_height;
    logic [ColW-1:0] r_col, r_row, n_col, n_row;
    logic [DimW-1:0] w_eff, h_eff, col13, row13;
    logic [ColW-1:0] col, row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WidthReset;
            r_height <= HeightReset;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_idx))
                REG_FRAME_WIDTH:  r_width  <= i_cfg_data;
                REG_FRAME_HEIGHT: r_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        w_eff  = clamp_dim(r_width, DimW'(MaxWidth));
        h_eff  = clamp_dim(r_height, DimW'(MaxHeight));
        col    = i_frame_start ? '0 : r_col;
        row    = i_frame_start ? '0 : r_row;
        col13  = {1'b0, col};
        row13  = {1'b0, row};

        o_item.px   = i_pixel_value;
        o_item.col  = col;
        o_item.wr   = col13 < w_eff;
        o_item.prod = (col13 < w_eff) && (col >= ColW'(2)) && (row >= ColW'(2))
                      && (row13 < h_eff);
        o_item.fend = (row13 == h_eff - 13'd1) && (col13 == w_eff - 13'd1);

        // Wrap at the row end; past the last row the frame starts over.
        if (col13 + 13'd1 >= w_eff) begin
            n_col = '0;
            n_row = (row13 + 13'd1 >= h_eff) ? '0 : row + ColW'(1);
        end else begin
            n_col = col + ColW'(1);
            n_row = row;
        end

        o_pix_ready = !i_q_full;
        o_push      = i_pix_valid && !i_q_full;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (o_push) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

endmodule

>>> hdl/sgm_queue.sv
// ----------------------------------------------------------------------------
// sgm_queue
// Small request queue between the front and the back.
// ----------------------------------------------------------------------------
module sgm_queue import sgm_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    input  logic  i_pop,
    output t_item o_item,
    output logic  o_full,
    output logic  o_empty
);

    t_item             r_mem [QDepth];
    logic [QPtrW-1:0]  r_wp, r_rp;
    logic [QCntW-1:0]  r_cnt;

    assign o_full  = r_cnt == QCntW'(QDepth);
    assign o_empty = r_cnt == '0;
    assign o_item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_item;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + QPtrW'(1);
            if (i_pop)  r_rp <= r_rp + QPtrW'(1);
            r_cnt <= r_cnt + QCntW'(i_push) - QCntW'(i_pop);
        end
    end

endmodule

>>> hdl/sgm_back.sv
// ----------------------------------------------------------------------------
// sgm_back
// Line store, 3x3 window, Sobel correlation, squaring and ceiling square root.
// ----------------------------------------------------------------------------
module sgm_back import sgm_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_empty,
    input  t_item           i_item,
    output logic            o_pop,
    output logic            o_res_valid,
    input  logic            i_res_ready,
    output logic [PixW-1:0] o_magnitude,
    output logic            o_frame_end
);

    logic adv;

    // Line store word: upper byte is the row two above, lower byte the row above.
    logic [2*PixW-1:0] mem [MaxWidth];
    logic [2*PixW-1:0] r_rd, r_fwd_data, word;
    logic              r_fwd;

    logic              r_v1;
    t_item             r_s1;
    logic [PixW-1:0]   mid, top;
    logic [PixW-1:0]   r_win [9];

    logic              r_v2, r_f2;
    logic              r_v3, r_f3;
    logic [AbsW-1:0]   r_ax, r_ay;
    logic              r_v4, r_f4;
    logic [SqW-1:0]    r_sqx, r_sqy;

    logic [SumW-1:0]   r_rs [RootBits+1];
    logic [RootBits-1:0] r_rr [RootBits+1];
    logic              r_rv [RootBits+1];
    logic              r_rf [RootBits+1];
    logic [RootBits-1:0] trial [RootBits];
    logic              keep [RootBits];

    logic signed [GradW-1:0] a [9];
    logic signed [GradW-1:0] gx, gy;
    logic [2*RootBits-1:0]   sq8;
    logic [PixW-1:0]         mag;

    logic            r_out_valid, r_out_fend;
    logic [PixW-1:0] r_out_mag;

    assign adv   = !r_out_valid || i_res_ready;
    assign o_pop = adv && !i_empty;

    assign word = r_fwd ? r_fwd_data : r_rd;
    assign mid  = word[PixW-1:0];
    assign top  = word[2*PixW-1:PixW];

    // Read the head's column while the previous request writes its own; a
    // write to the same column in that cycle is forwarded.
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_rd <= mem[i_item.col];
            if (r_v1 && r_s1.wr) mem[r_s1.col] <= {mid, r_s1.px};
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1       <= i_item;
            r_fwd_data <= {mid, r_s1.px};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1  <= 1'b0;
            r_fwd <= 1'b0;
            for (int k = 0; k < 9; k++) r_win[k] <= '0;
        end else if (adv) begin
            r_v1  <= o_pop;
            r_fwd <= o_pop && r_v1 && r_s1.wr && (r_s1.col == i_item.col);
            if (r_v1 && r_s1.wr) begin
                for (int k = 0; k < 3; k++) begin
                    r_win[k*3+0] <= r_win[k*3+1];
                    r_win[k*3+1] <= r_win[k*3+2];
                end
                r_win[2] <= top;
                r_win[5] <= mid;
                r_win[8] <= r_s1.px;
            end
        end
    end

    always_comb begin
        for (int k = 0; k < 9; k++) a[k] = $signed({3'b000, r_win[k]});
        gx = GradW'((a[0] + 2*a[3] + a[6]) - (a[2] + 2*a[5] + a[8]));
        gy = GradW'((a[0] + 2*a[1] + a[2]) - (a[6] + 2*a[7] + a[8]));
    end

    // Root stages each settle one bit of the floor square root, MSB first.
    always_comb begin
        for (int i = 0; i < RootBits; i++) begin
            trial[i] = r_rr[i] | RootBits'(1 << (RootBits-1-i));
            keep[i]  = SumW'(trial[i] * trial[i]) <= r_rs[i];
        end
        sq8 = r_rr[RootBits] * r_rr[RootBits];
        if (r_rs[RootBits] > SumW'(SatLevel*SatLevel))  mag = PixW'(SatLevel);
        else if (SumW'(sq8) == r_rs[RootBits])           mag = r_rr[RootBits];
        else                                             mag = r_rr[RootBits] + PixW'(1);
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_f2  <= r_s1.fend;
            r_f3  <= r_f2;
            r_ax  <= AbsW'(gx < 0 ? -gx : gx);
            r_ay  <= AbsW'(gy < 0 ? -gy : gy);
            r_f4  <= r_f3;
            r_sqx <= r_ax * r_ax;
            r_sqy <= r_ay * r_ay;
            r_rs[0] <= SumW'(r_sqx) + SumW'(r_sqy);
            r_rr[0] <= '0;
            r_rf[0] <= r_f4;
            for (int i = 0; i < RootBits; i++) begin
                r_rs[i+1] <= r_rs[i];
                r_rr[i+1] <= keep[i] ? trial[i] : r_rr[i];
                r_rf[i+1] <= r_rf[i];
            end
            r_out_mag  <= mag;
            r_out_fend <= r_rf[RootBits];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            for (int i = 0; i <= RootBits; i++) r_rv[i] <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_v2    <= r_v1 && r_s1.prod;
            r_v3    <= r_v2;
            r_v4    <= r_v3;
            r_rv[0] <= r_v4;
            for (int i = 0; i < RootBits; i++) r_rv[i+1] <= r_rv[i];
            r_out_valid <= r_rv[RootBits];
        end
    end

    assign o_res_valid = r_out_valid;
    assign o_magnitude = r_out_mag;
    assign o_frame_end = r_out_fend;

    a_fwd_has_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fwd |-> r_v1)
        else $error("forwarded line data without a request in the read stage");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 && !adv |=> r_v1 && $stable(r_s1.col))
        else $error("read stage request moved during a stall");

    a_root_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rv[RootBits] && r_rs[RootBits] <= SumW'(SatLevel*SatLevel)
        |-> SumW'(sq8) <= r_rs[RootBits])
        else $error("square root stage overshot");

endmodule

>>> hdl/sobel_gradient_magnitude.sv
// ----------------------------------------------------------------------------
// sobel_gradient_magnitude
// 3x3 Sobel edge magnitude over a raster greyscale pixel stream.
// ----------------------------------------------------------------------------
// Pixels enter in raster order on the i_pix_valid / o_pix_ready channel, one
// request per accepted edge; i_frame_start marks row 0, column 0 of a frame.
// Frame size comes from two registers on the plain write port (index 0 is the
// width, index 1 the height, 640 x 480 after reset); values are clamped to
// 3..4096 and may only change while the block is idle.
// Only interior pixels give a result, on o_res_valid / i_res_ready: the ceiling
// of sqrt(gx^2 + gy^2) saturated at 255, with o_frame_end on the last interior
// result of a frame. A result appears once the pixel one row below and one
// column right of its center has been taken. Throughput is one pixel per clock
// while the receiver does not stall: the line store is one memory port pair,
// read and written for each request, and the square root is an 8-stage
// pipeline. A four-entry queue separates the position counters from the
// datapath. When the receiver stalls the datapath freezes, the queue fills
// and then o_pix_ready drops. Reset clears counters, queue, window and valid
// flags; line store contents are not cleared.
// ----------------------------------------------------------------------------
module sobel_gradient_magnitude import sgm_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [CfgIdxW-1:0] i_cfg_idx,
    input  logic [DimW-1:0]    i_cfg_data,
    input  logic               i_pix_valid,
    output logic               o_pix_ready,
    input  logic [PixW-1:0]    i_pixel_value,
    input  logic               i_frame_start,
    output logic               o_res_valid,
    input  logic               i_res_ready,
    output logic [PixW-1:0]    o_magnitude,
    output logic               o_frame_end
);

    t_item push_item, head_item;
    logic  push, pop, q_full, q_empty;

    // Front: registers, position counters and classification of each request.
    sgm_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_pix_valid   (i_pix_valid),
        .o_pix_ready   (o_pix_ready),
        .i_pixel_value (i_pixel_value),
        .i_frame_start (i_frame_start),
        .i_q_full      (q_full),
        .o_push        (push),
        .o_item        (push_item)
    );

    sgm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .i_pop   (pop),
        .o_item  (head_item),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    // Back: line store, window, gradients and the magnitude pipeline.
    sgm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (q_empty),
        .i_item      (head_item),
        .o_pop       (pop),
        .o_res_valid (o_res_valid),
        .i_res_ready (i_res_ready),
        .o_magnitude (o_magnitude),
        .o_frame_end (o_frame_end)
    );

endmodule
